FILE: design/pled_pkg.sv
`timescale 1ns / 1ps

package pled_pkg;

    // Fixed geometry of the rule file and the status word
    localparam int RULE_SLOTS = 8;
    localparam int RULE_IDX_W = 3;
    localparam int CFG_IDX_W  = 4;
    localparam int RULE_W     = 24;
    localparam int FLAGS_W    = 16;
    localparam int PIN_W      = 3;
    localparam int PHASE_W    = 7;
    localparam int PROD_W     = 13;

    // Phase runs 0..99, one step per tick
    localparam logic [PHASE_W-1:0] PHASE_LAST = 7'd99;

    // Off ratio is given in twentieths of the period
    localparam logic [4:0] RATIO_FULL = 5'd20;

    // Default level codes; the top code acts like default on
    localparam logic [1:0] DFLT_NONE = 2'd0;
    localparam logic [1:0] DFLT_OFF  = 2'd1;
    localparam logic [1:0] DFLT_ON   = 2'd2;

    // One rule word, MSB first
    typedef struct packed {
        logic [3:0] flag;
        logic       flag_inv;
        logic       out_inv;
        logic [1:0] dflt;
        logic [2:0] pin;
        logic [4:0] ratio;
        logic [7:0] period;
    } t_rule;

    // Verdict of the shared rule evaluator for the current rule
    typedef struct packed {
        logic             write;
        logic             claim;
        logic             on;
        logic             level;
        logic [PIN_W-1:0] pin;
    } t_eval;

endpackage

FILE: design/pled_ifs.sv
`timescale 1ns / 1ps

// Tick request channel
interface pled_in_if;
    logic                         valid;
    logic                         ready;
    logic [pled_pkg::FLAGS_W-1:0] status_flags;

    modport source (output valid, output status_flags, input ready);
    modport sink   (input valid, input status_flags, output ready);
endinterface

// Pin write channel
interface pled_out_if;
    logic                       valid;
    logic                       ready;
    logic [pled_pkg::PIN_W-1:0] pin_number;
    logic                       pin_level;
    logic                       last_write;

    modport source (output valid, output pin_number, output pin_level,
                    output last_write, input ready);
    modport sink   (input valid, input pin_number, input pin_level,
                    input last_write, output ready);
endinterface

// Rule register write channel
interface pled_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [pled_pkg::CFG_IDX_W-1:0] index;
    logic [pled_pkg::RULE_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: design/pled_cfg_regs.sv
`timescale 1ns / 1ps

module pled_cfg_regs (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    pled_cfg_if.sink              i_cfg,
    output pled_pkg::t_rule       o_rules [pled_pkg::RULE_SLOTS]
);

    pled_pkg::t_rule r_rules [pled_pkg::RULE_SLOTS];

    // Always take register writes
    assign i_cfg.ready = 1'b1;

    // Write the addressed rule word; drop writes beyond the rule file
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < pled_pkg::RULE_SLOTS; i++) begin
                r_rules[i] <= '0;
            end
        end else if (i_cfg.valid) begin
            for (int i = 0; i < pled_pkg::RULE_SLOTS; i++) begin
                if (i_cfg.index == pled_pkg::CFG_IDX_W'(i)) begin
                    r_rules[i] <= pled_pkg::t_rule'(i_cfg.data);
                end
            end
        end
    end

    assign o_rules = r_rules;

endmodule

FILE: design/pled_rule_eval.sv
`timescale 1ns / 1ps

module pled_rule_eval #(
    parameter int NUM_LEDS = 3,
    parameter int PIN_BASE = 0
) (
    input  pled_pkg::t_rule                  i_rule,
    input  logic [pled_pkg::FLAGS_W-1:0]     i_flags,
    input  logic [pled_pkg::PHASE_W-1:0]     i_phase,
    input  logic                             i_rec_on,
    input  logic [pled_pkg::PHASE_W-1:0]     i_rec_stamp,
    input  logic [7:0]                       i_claimed,
    output pled_pkg::t_eval                  o_eval
);

    localparam logic [3:0] PIN_LO = 4'(PIN_BASE);
    localparam logic [3:0] PIN_HI = 4'(PIN_BASE + NUM_LEDS);

    logic                          w_in_range;
    logic                          w_match;
    logic [4:0]                    w_ratio;
    logic [pled_pkg::PROD_W-1:0]   w_prod;
    logic                          w_toff_zero;
    logic                          w_wrapped;
    logic [pled_pkg::PHASE_W-1:0]  w_elapsed;
    logic [7:0]                    w_elapsed8;
    logic [pled_pkg::PROD_W-1:0]   w_off_bound;
    logic [7:0]                    w_on_left;
    logic [pled_pkg::PROD_W-1:0]   w_on_bound;
    logic                          w_off_done;
    logic                          w_on_done;
    logic                          w_target;
    logic                          w_write;
    logic                          w_on;

    // Decode rule position and flag match
    assign w_in_range = ({1'b0, i_rule.pin} >= PIN_LO) && ({1'b0, i_rule.pin} < PIN_HI);
    assign w_match    = i_flags[i_rule.flag] ^ i_rule.flag_inv;

    // Scale the period by the clamped ratio; t_off is this product over 20
    assign w_ratio     = (i_rule.ratio > pled_pkg::RATIO_FULL) ? pled_pkg::RATIO_FULL
                                                               : i_rule.ratio;
    assign w_prod      = pled_pkg::PROD_W'(i_rule.period) * pled_pkg::PROD_W'(w_ratio);
    assign w_toff_zero = (w_prod < pled_pkg::PROD_W'(pled_pkg::RATIO_FULL));

    // Elapsed ticks since the last write
    assign w_wrapped  = (i_phase < i_rec_stamp);
    assign w_elapsed  = i_phase - i_rec_stamp;
    assign w_elapsed8 = {1'b0, w_elapsed};

    // Off phase over: elapsed >= floor(prod/20), i.e. prod < 20*(elapsed+1)
    assign w_off_bound = (pled_pkg::PROD_W'(w_elapsed8) + 1'b1) * 13'd20;
    assign w_off_done  = (w_prod < w_off_bound);

    // On phase over: elapsed >= period - floor(prod/20)
    assign w_on_left  = i_rule.period - w_elapsed8;
    assign w_on_bound = pled_pkg::PROD_W'(w_on_left) * 13'd20;
    assign w_on_done  = (w_elapsed8 >= i_rule.period) || (w_prod >= w_on_bound);

    // Default level with output inversion
    assign w_target = (i_rule.dflt >= pled_pkg::DFLT_ON) ^ i_rule.out_inv;

    // Pick the write for this rule
    always_comb begin
        w_write = 1'b0;
        w_on    = 1'b0;
        if (w_match) begin
            if ((i_rec_stamp == '0) || w_toff_zero) begin
                w_write = 1'b1;
                w_on    = 1'b1;
            end else if (i_rec_on) begin
                w_write = w_wrapped || w_on_done;
                w_on    = 1'b0;
            end else begin
                w_write = w_wrapped || w_off_done;
                w_on    = 1'b1;
            end
        end else if (i_rule.dflt != pled_pkg::DFLT_NONE) begin
            w_write = (w_target != i_rec_on);
            w_on    = w_target;
        end
    end

    // Skip rules off the LED range or on a pin already claimed this tick
    always_comb begin
        o_eval.write = 1'b0;
        o_eval.claim = 1'b0;
        if (w_in_range && !i_claimed[i_rule.pin]) begin
            o_eval.write = w_write;
            o_eval.claim = w_match;
        end
        o_eval.on    = w_on;
        o_eval.level = w_on ^ i_rule.out_inv ^ 1'b1;
        o_eval.pin   = i_rule.pin;
    end

endmodule

FILE: design/prioritized_led_blink_engine.sv
`timescale 1ns / 1ps

// Prioritized LED blink engine.
// i_in carries one request per 100 ms tick with sixteen status flags.
// i_cfg writes rule words 0..7 (index 8 and above is dropped); write it
// only while the engine is idle. o_out carries pin writes (pin number,
// active-low level, last_write on the final write of a tick).
// Each tick request advances the phase (0..99) and scans rules 0 to
// NUM_RULES-1, one rule per cycle, through a single shared evaluator
// holding one period-by-ratio multiplier. A tick passes through acceptance,
// the scan of every rule and a flush step that marks the last write. The
// first write passes through the pending slot and the output register
// before it leaves o_out. One write is held back in a pending slot so the
// last one can be marked; if the current rule writes while o_out stalls
// with a write already waiting, the scan holds on that rule until the
// output register frees. A tick that produces no write produces no
// output. Reset clears the phase, all LED records (off, stamp zero), the
// rule words and both output and pending slots.
module prioritized_led_blink_engine #(
    parameter int NUM_RULES = 8,
    parameter int NUM_LEDS  = 3,
    parameter int PIN_BASE  = 0
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    pled_in_if.sink       i_in,
    pled_out_if.source    o_out,
    pled_cfg_if.sink      i_cfg
);

    localparam logic [pled_pkg::RULE_IDX_W-1:0] RULE_LAST =
        pled_pkg::RULE_IDX_W'(NUM_RULES - 1);
    localparam logic [15:0] LED_MASK16 = 16'(((1 << NUM_LEDS) - 1) << PIN_BASE);
    localparam logic [7:0]  LED_MASK   = LED_MASK16[7:0];

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FLUSH
    } t_state;

    pled_pkg::t_rule w_rules [pled_pkg::RULE_SLOTS];
    pled_pkg::t_rule w_rule;
    pled_pkg::t_eval w_eval;

    t_state                               r_state, n_state;
    logic [pled_pkg::RULE_IDX_W-1:0]      r_rule, n_rule;
    logic [pled_pkg::PHASE_W-1:0]         r_phase, n_phase;
    logic [7:0]                           r_claimed, n_claimed;
    logic [pled_pkg::FLAGS_W-1:0]         r_flags, n_flags;
    logic                                 r_rec_on [NUM_LEDS];
    logic [pled_pkg::PHASE_W-1:0]         r_rec_stamp [NUM_LEDS];
    logic                                 r_pend_valid, n_pend_valid;
    logic [pled_pkg::PIN_W-1:0]           r_pend_pin, n_pend_pin;
    logic                                 r_pend_level, n_pend_level;
    logic                                 r_out_valid, n_out_valid;
    logic [pled_pkg::PIN_W-1:0]           r_out_pin, n_out_pin;
    logic                                 r_out_level, n_out_level;
    logic                                 r_out_last, n_out_last;

    logic [3:0]                           w_slot;
    logic                                 w_rec_on;
    logic [pled_pkg::PHASE_W-1:0]         w_rec_stamp;
    logic                                 w_out_free;
    logic                                 w_step;
    logic                                 w_rec_we;

    // Rule register file
    pled_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_rules (w_rules)
    );

    assign w_rule = w_rules[r_rule];

    // Select the LED record of the current rule's pin
    assign w_slot = {1'b0, w_rule.pin} - 4'(PIN_BASE);
    always_comb begin
        w_rec_on    = 1'b0;
        w_rec_stamp = '0;
        for (int j = 0; j < NUM_LEDS; j++) begin
            if (w_slot == 4'(j)) begin
                w_rec_on    = r_rec_on[j];
                w_rec_stamp = r_rec_stamp[j];
            end
        end
    end

    // Shared rule evaluator
    pled_rule_eval #(
        .NUM_LEDS (NUM_LEDS),
        .PIN_BASE (PIN_BASE)
    ) u_eval (
        .i_rule      (w_rule),
        .i_flags     (r_flags),
        .i_phase     (r_phase),
        .i_rec_on    (w_rec_on),
        .i_rec_stamp (w_rec_stamp),
        .i_claimed   (r_claimed),
        .o_eval      (w_eval)
    );

    assign w_out_free = !r_out_valid || o_out.ready;
    assign i_in.ready = (r_state == S_IDLE);

    // Hold the scan only when a new write meets a full pending slot and a busy output
    assign w_step   = (r_state == S_SCAN) &&
                      !(w_eval.write && r_pend_valid && !w_out_free);
    assign w_rec_we = w_step && w_eval.write;

    // Sequencer and output datapath
    always_comb begin
        n_state      = r_state;
        n_rule       = r_rule;
        n_phase      = r_phase;
        n_claimed    = r_claimed;
        n_flags      = r_flags;
        n_pend_valid = r_pend_valid;
        n_pend_pin   = r_pend_pin;
        n_pend_level = r_pend_level;
        n_out_valid  = r_out_valid && !o_out.ready;
        n_out_pin    = r_out_pin;
        n_out_level  = r_out_level;
        n_out_last   = r_out_last;

        unique case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_phase   = (r_phase >= pled_pkg::PHASE_LAST) ? '0 : r_phase + 1'b1;
                    n_claimed = '0;
                    n_flags   = i_in.status_flags;
                    n_rule    = '0;
                    n_state   = S_SCAN;
                end
            end
            S_SCAN: begin
                if (w_step) begin
                    if (w_eval.write) begin
                        // Push the older write out, keep the new one pending
                        if (r_pend_valid) begin
                            n_out_valid = 1'b1;
                            n_out_pin   = r_pend_pin;
                            n_out_level = r_pend_level;
                            n_out_last  = 1'b0;
                        end
                        n_pend_valid = 1'b1;
                        n_pend_pin   = w_eval.pin;
                        n_pend_level = w_eval.level;
                    end
                    if (w_eval.claim) begin
                        n_claimed = r_claimed | (8'd1 << w_eval.pin);
                    end
                    if (r_rule == RULE_LAST) begin
                        n_state = S_FLUSH;
                    end else begin
                        n_rule = r_rule + 1'b1;
                    end
                end
            end
            S_FLUSH: begin
                // Release the pending write as the last of this tick
                if (!r_pend_valid) begin
                    n_state = S_IDLE;
                end else if (w_out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_pin    = r_pend_pin;
                    n_out_level  = r_pend_level;
                    n_out_last   = 1'b1;
                    n_pend_valid = 1'b0;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State, records and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_rule       <= '0;
            r_phase      <= '0;
            r_claimed    <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
            for (int j = 0; j < NUM_LEDS; j++) begin
                r_rec_on[j]    <= 1'b0;
                r_rec_stamp[j] <= '0;
            end
        end else begin
            r_state      <= n_state;
            r_rule       <= n_rule;
            r_phase      <= n_phase;
            r_claimed    <= n_claimed;
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
            for (int j = 0; j < NUM_LEDS; j++) begin
                if (w_rec_we && (w_slot == 4'(j))) begin
                    r_rec_on[j]    <= w_eval.on;
                    r_rec_stamp[j] <= r_phase;
                end
            end
        end
        r_flags      <= n_flags;
        r_pend_pin   <= n_pend_pin;
        r_pend_level <= n_pend_level;
        r_out_pin    <= n_out_pin;
        r_out_level  <= n_out_level;
        r_out_last   <= n_out_last;
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.pin_number = r_out_pin;
    assign o_out.pin_level  = r_out_level;
    assign o_out.last_write = r_out_last;

    // Nothing may stay pending once a tick is finished
    a_idle_no_pend : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !r_pend_valid)
        else $error("pending write left over after tick");

    // Phase stays within one period of 100 ticks
    a_phase_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase <= pled_pkg::PHASE_LAST)
        else $error("phase out of range");

    // Only pins within the LED range can be claimed
    a_claim_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_claimed & ~LED_MASK) == 8'd0)
        else $error("claim outside LED range");

    // A tick request is taken only after the last write of the previous tick left the pending slot
    a_accept_flushed : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> (r_state == S_SCAN) && !r_pend_valid)
        else $error("scan started with stale pending write");

endmodule
